[rtl/core/fixed_chunk_free_list_allocator_macros.svh]
// Assertion macros shared by the free list allocator RTL
`ifndef FIXED_CHUNK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_CHUNK_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset
`define FCFLA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset
`define FCFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fcfla_pkg.sv]
// Types, constants and helpers for the fixed chunk free list allocator
`default_nettype none

package fcfla_pkg;

    // Pool geometry
    localparam int NUM_CHUNKS = 64;
    localparam int IDX_W      = $clog2(NUM_CHUNKS);
    localparam int LINK_W     = $clog2(NUM_CHUNKS + 1);
    localparam int REQ_IDX_W  = 7;
    localparam int GRANT_W    = 6;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SOFT_FAIL = 2'd1,
        ST_ABORT     = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Request kinds
    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } state_t;

    // Link value of a chunk that has not been written since reset
    function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] addr);
        logic [LINK_W-1:0] link;
        if (addr == '0)
            link = LINK_W'(NUM_CHUNKS);
        else
            link = LINK_W'(addr) - LINK_W'(1);
        return link;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fixed_chunk_free_list_allocator.sv]
// Free list allocator: head register, link memory and result register
// The result is held in registers that are loaded on the input transfer.
// A free or a failed allocate leaves the block ready for a new request once the result is taken;
// a successful allocate adds S_FETCH, as the new head comes from the link memory's registered read.
// Reset: head is the highest chunk and each chunk links to the one below it;
// per-entry valid bits give the reset links, so no clearing pass is run.
`default_nettype none

`include "fixed_chunk_free_list_allocator_macros.svh"

module fixed_chunk_free_list_allocator
    import fcfla_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 mode,
    input  wire logic [REQ_IDX_W-1:0] chunk_index,
    input  wire logic                 soft_fail,
    input  wire logic                 zero_fill,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [GRANT_W-1:0]        granted_index,
    output logic [1:0]                status,
    output logic                      clear_chunk
);

    localparam logic [REQ_IDX_W-1:0] REQ_LIMIT  = REQ_IDX_W'(NUM_CHUNKS);
    localparam logic [LINK_W-1:0]    HEAD_LIMIT = LINK_W'(NUM_CHUNKS);

    // Link memory and its written marks
    logic [LINK_W-1:0]     link_mem [NUM_CHUNKS];
    logic [NUM_CHUNKS-1:0] link_vld_reg;

    state_t               state_reg, state_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;
    logic [LINK_W-1:0]    rd_dflt_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [GRANT_W-1:0]   granted_reg, granted_next;
    status_t              status_reg, status_next;
    logic                 clear_reg, clear_next;

    logic                 in_xfer;
    logic                 head_ok;
    logic                 free_ok;
    logic                 pop;
    logic                 push;
    logic [IDX_W-1:0]     head_addr;
    logic [IDX_W-1:0]     free_addr;

    // Decode the request
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_xfer   = in_valid && in_ready;
    assign head_ok   = head_reg < HEAD_LIMIT;
    assign free_ok   = chunk_index < REQ_LIMIT;
    assign head_addr = head_reg[IDX_W-1:0];
    assign free_addr = chunk_index[IDX_W-1:0];
    assign pop       = in_xfer && (mode == MODE_ALLOC) && head_ok;
    assign push      = in_xfer && (mode == MODE_FREE) && free_ok;

    // Work out the next head, state and result
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        clear_next     = clear_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = '0;
                    status_next    = ST_OK;
                    clear_next     = 1'b0;
                    if (mode == MODE_ALLOC)
                    begin
                        if (head_ok)
                        begin
                            granted_next = GRANT_W'(head_addr);
                            clear_next   = zero_fill;
                            state_next   = S_FETCH;
                        end
                        else
                        begin
                            status_next = soft_fail ? ST_SOFT_FAIL : ST_ABORT;
                        end
                    end
                    else
                    begin
                        if (free_ok)
                            head_next = LINK_W'(chunk_index);
                        else
                            status_next = ST_RANGE;
                    end
                end
            end
            S_FETCH:
            begin
                // take the popped chunk's link as the new head
                head_next  = rd_vld_reg ? rd_data_reg : rd_dflt_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= LINK_W'(NUM_CHUNKS - 1);
            out_valid_reg <= 1'b0;
            link_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            if (push)
                link_vld_reg[free_addr] <= 1'b1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        granted_reg <= granted_next;
        status_reg  <= status_next;
        clear_reg   <= clear_next;
    end

    // Link memory: write on an in-range free, registered read of the head's link on pop
    always_ff @(posedge clk)
    begin
        if (push)
            link_mem[free_addr] <= head_reg;
        if (pop)
        begin
            rd_data_reg <= link_mem[head_addr];
            rd_vld_reg  <= link_vld_reg[head_addr];
            rd_dflt_reg <= reset_link(head_addr);
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;
    assign clear_chunk   = clear_reg;

    // Checks on the controller
    `FCFLA_ASSERT_NEXT(a_fetch_one_cycle, state_reg == S_FETCH, state_reg == S_IDLE, "fetch held")
    `FCFLA_ASSERT_SAME(a_no_xfer_in_fetch, state_reg == S_FETCH, !in_ready, "input during fetch")
    `FCFLA_ASSERT_NEXT(a_pop_fetches, pop, state_reg == S_FETCH && out_valid, "pop without fetch")
    `FCFLA_ASSERT_SAME(a_head_bound, 1'b1, head_reg <= HEAD_LIMIT, "head beyond none marker")

endmodule

`default_nettype wire

[dv/tb_fixed_chunk_free_list_allocator.sv]
// Testbench for the fixed chunk free list allocator: random traffic against a free list predictor
`timescale 1ns / 1ps

module tb_fixed_chunk_free_list_allocator;
    import fcfla_pkg::*;

    // One result of the allocator, as the predictor expects it
    typedef struct packed {
        logic [GRANT_W-1:0] grant;
        status_t            st;
        logic               clr;
    } grant_result_t;

    // Free list predictor and store of results still owed by the block
    class chunk_pool_scoreboard;
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] links [NUM_CHUNKS];
        grant_result_t     owed[$];
        grant_result_t     last_result;
        int                mismatches;

        function new();
            head     = LINK_W'(NUM_CHUNKS - 1);
            links[0] = LINK_W'(NUM_CHUNKS);
            for (int i = 1; i < NUM_CHUNKS; i++)
                links[i] = LINK_W'(i - 1);
            mismatches = 0;
        endfunction

        // Apply one accepted request to the list and queue its result
        function void note_request(logic m, logic [REQ_IDX_W-1:0] idx, logic sf, logic zf);
            grant_result_t r;
            r.grant = '0;
            r.st    = ST_OK;
            r.clr   = 1'b0;
            if (m == MODE_ALLOC)
            begin
                // a head of NUM_CHUNKS or above means the list is empty
                if (head < LINK_W'(NUM_CHUNKS))
                begin
                    r.grant = head[GRANT_W-1:0];
                    r.clr   = zf;
                    head    = links[head[IDX_W-1:0]];
                end
                else
                    r.st = sf ? ST_SOFT_FAIL : ST_ABORT;
            end
            else if (idx < REQ_IDX_W'(NUM_CHUNKS))
            begin
                // push without any double free check
                links[idx[IDX_W-1:0]] = head;
                head = LINK_W'(idx);
            end
            else
                r.st = ST_RANGE;
            owed.push_back(r);
            last_result = r;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one result transfer with the oldest owed result
        task check_result(logic [GRANT_W-1:0] g, logic [1:0] s, logic c);
            grant_result_t e;
            if (owed.size() == 0)
                report_mismatch($sformatf("unexpected result: index %0d code %0d", g, s));
            else
            begin
                e = owed.pop_front();
                if (g !== e.grant)
                    report_mismatch($sformatf("granted_index got %0d exp %0d", g, e.grant));
                if (s !== e.st)
                    report_mismatch($sformatf("status got %0d exp %0d", s, e.st));
                if (c !== e.clr)
                    report_mismatch($sformatf("clear_chunk got %0d exp %0d", c, e.clr));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 mode;
    logic [REQ_IDX_W-1:0] chunk_index;
    logic                 soft_fail;
    logic                 zero_fill;
    logic                 out_valid;
    logic                 out_ready;
    logic [GRANT_W-1:0]   granted_index;
    logic [1:0]           status;
    logic                 clear_chunk;

    chunk_pool_scoreboard sb = new();

    int idle_pct;
    int stall_pct;
    bit hold_active;
    int item_count;
    int held_chunks[$];

    fixed_chunk_free_list_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .chunk_index   (chunk_index),
        .soft_fail     (soft_fail),
        .zero_fill     (zero_fill),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_index (granted_index),
        .status        (status),
        .clear_chunk   (clear_chunk)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Drive the receiver side: random stalls, or a long hold-off when asked
    initial out_ready = 1'b0;
    always @(negedge clk)
    begin
        out_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end

    // Sample both channels on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(mode, chunk_index, soft_fail, zero_fill);
            if (out_valid && out_ready)
                sb.check_result(granted_index, status, clear_chunk);
        end
    end

    // Offer one request and hold it until the transfer; called at a falling edge
    task automatic send_item(input logic m, input logic [REQ_IDX_W-1:0] idx,
                             input logic sf, input logic zf);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        chunk_index  <= idx;
        soft_fail    <= sf;
        zero_fill    <= zf;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        item_count++;
        // track granted chunks so that later frees are well formed
        if (m == MODE_ALLOC && sb.last_result.st == ST_OK)
            held_chunks.push_back(int'(sb.last_result.grant));
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(negedge clk);
    endtask

    // Swing between allocation-heavy and free-heavy windows to empty and refill the list
    task automatic run_random(input int count, input bit with_double_free);
        int r;
        int bias;
        int k;
        int idx;
        for (int i = 0; i < count; i++)
        begin
            bias = ((item_count / 100) % 2 == 0) ? 85 : 20;
            r = $urandom_range(99);
            if (r < 4)
                send_item(MODE_FREE, REQ_IDX_W'($urandom_range(127, NUM_CHUNKS)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (with_double_free && r < 6)
                send_item(MODE_FREE, REQ_IDX_W'($urandom_range(NUM_CHUNKS - 1, 0)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else if ($urandom_range(99) < bias || held_chunks.size() == 0)
                send_item(MODE_ALLOC, REQ_IDX_W'($urandom_range(127, 0)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
            begin
                k   = $urandom_range(held_chunks.size() - 1, 0);
                idx = held_chunks[k];
                held_chunks.delete(k);
                send_item(MODE_FREE, REQ_IDX_W'(idx), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
        end
    endtask

    // Set the idling of both sides; written on the rising edge, read on the falling one
    task automatic set_idling(input int send_idle, input int recv_stall);
        @(posedge clk);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        @(negedge clk);
    endtask

    // Main sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_ALLOC;
        chunk_index  = '0;
        soft_fail    = 1'b0;
        zero_fill    = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_active  = 1'b0;
        item_count   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, ignored inputs, range errors
        send_item(MODE_ALLOC, 7'd0, 1'b0, 1'b1);
        send_item(MODE_ALLOC, 7'd127, 1'b1, 1'b0);
        send_item(MODE_FREE, 7'd127, 1'b1, 1'b1);
        send_item(MODE_FREE, REQ_IDX_W'(NUM_CHUNKS), 1'b0, 1'b0);
        send_item(MODE_FREE, REQ_IDX_W'(NUM_CHUNKS - 1), 1'b1, 1'b1);
        send_item(MODE_ALLOC, 7'd127, 1'b1, 1'b1);
        send_item(MODE_FREE, REQ_IDX_W'(NUM_CHUNKS - 2), 1'b0, 1'b1);
        send_item(MODE_FREE, REQ_IDX_W'(NUM_CHUNKS - 1), 1'b1, 1'b0);
        held_chunks.delete();
        wait_all_results();

        // No idling, with a long receiver hold-off while requests keep coming
        set_idling(0, 0);
        fork
        begin
            @(posedge clk);
            hold_active = 1'b1;
            repeat (300) @(posedge clk);
            hold_active = 1'b0;
        end
        join_none
        run_random(230, 1'b0);
        wait_all_results();

        set_idling(60, 0);
        run_random(220, 1'b0);
        wait_all_results();

        set_idling(0, 60);
        run_random(220, 1'b0);
        wait_all_results();

        // Last phase adds double frees, which may leave a cycle in the list
        set_idling(9, 9);
        run_random(220, 1'b1);
        wait_all_results();

        repeat (8) @(posedge clk);
        if (sb.owed.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.owed.size()));
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
